>>> src/magnus_dew_point_fixed_core_defines.svh
// Assertion helpers for the dew point core
`ifndef MAGNUS_DEW_POINT_FIXED_CORE_DEFINES_SVH
`define MAGNUS_DEW_POINT_FIXED_CORE_DEFINES_SVH

`define MDP_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("mdp assertion failed");

`define MDP_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("mdp assertion failed");

`endif

>>> src/mdp_pkg.sv
`default_nettype none

package mdp_pkg;

  localparam logic [14:0] MagA = 15'd17684;
  localparam logic [14:0] MagB = 15'd23770;
  localparam logic [13:0] RhFloor = 14'd100;
  localparam logic [13:0] RhTop = 14'd10000;
  localparam logic [6:0] PctTop = 7'd100;
  localparam logic [6:0] Cent = 7'd100;
  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_MATH  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_TEMP_MIN = 2'd0,
    CFG_TEMP_MAX = 2'd1,
    CFG_RH_MAX   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic [15:0]        humidity;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic signed [15:0] dew_point;
  } result_t;

  typedef struct packed {
    logic signed [15:0] temp_min;
    logic signed [15:0] temp_max;
    logic [13:0]        rh_max;
  } cfg_t;

  typedef struct packed {
    status_e            status;
    logic signed [15:0] temp;
    logic [15:0]        den;
    logic signed [13:0] ln_h;
  } item_t;

  // magnitude of round(ln(p/100) * 1024)
  function automatic logic [12:0] ln_mag(input logic [6:0] p);
    logic [12:0] m;
    unique case (p)
      7'd1: m = 13'd4716;   7'd2: m = 13'd4006;   7'd3: m = 13'd3591;
      7'd4: m = 13'd3296;   7'd5: m = 13'd3068;   7'd6: m = 13'd2881;
      7'd7: m = 13'd2723;   7'd8: m = 13'd2586;   7'd9: m = 13'd2466;
      7'd10: m = 13'd2358;  7'd11: m = 13'd2260;  7'd12: m = 13'd2171;
      7'd13: m = 13'd2089;  7'd14: m = 13'd2013;  7'd15: m = 13'd1943;
      7'd16: m = 13'd1877;  7'd17: m = 13'd1814;  7'd18: m = 13'd1756;
      7'd19: m = 13'd1701;  7'd20: m = 13'd1648;  7'd21: m = 13'd1598;
      7'd22: m = 13'd1550;  7'd23: m = 13'd1505;  7'd24: m = 13'd1461;
      7'd25: m = 13'd1420;  7'd26: m = 13'd1379;  7'd27: m = 13'd1341;
      7'd28: m = 13'd1304;  7'd29: m = 13'd1268;  7'd30: m = 13'd1233;
      7'd31: m = 13'd1199;  7'd32: m = 13'd1167;  7'd33: m = 13'd1135;
      7'd34: m = 13'd1105;  7'd35: m = 13'd1075;  7'd36: m = 13'd1046;
      7'd37: m = 13'd1018;  7'd38: m = 13'd991;   7'd39: m = 13'd964;
      7'd40: m = 13'd938;   7'd41: m = 13'd913;   7'd42: m = 13'd888;
      7'd43: m = 13'd864;   7'd44: m = 13'd841;   7'd45: m = 13'd818;
      7'd46: m = 13'd795;   7'd47: m = 13'd773;   7'd48: m = 13'd752;
      7'd49: m = 13'd730;   7'd50: m = 13'd710;   7'd51: m = 13'd690;
      7'd52: m = 13'd670;   7'd53: m = 13'd650;   7'd54: m = 13'd631;
      7'd55: m = 13'd612;   7'd56: m = 13'd594;   7'd57: m = 13'd576;
      7'd58: m = 13'd558;   7'd59: m = 13'd540;   7'd60: m = 13'd523;
      7'd61: m = 13'd506;   7'd62: m = 13'd490;   7'd63: m = 13'd473;
      7'd64: m = 13'd457;   7'd65: m = 13'd441;   7'd66: m = 13'd425;
      7'd67: m = 13'd410;   7'd68: m = 13'd395;   7'd69: m = 13'd380;
      7'd70: m = 13'd365;   7'd71: m = 13'd351;   7'd72: m = 13'd336;
      7'd73: m = 13'd322;   7'd74: m = 13'd308;   7'd75: m = 13'd295;
      7'd76: m = 13'd281;   7'd77: m = 13'd268;   7'd78: m = 13'd254;
      7'd79: m = 13'd241;   7'd80: m = 13'd228;   7'd81: m = 13'd216;
      7'd82: m = 13'd203;   7'd83: m = 13'd191;   7'd84: m = 13'd179;
      7'd85: m = 13'd166;   7'd86: m = 13'd154;   7'd87: m = 13'd143;
      7'd88: m = 13'd131;   7'd89: m = 13'd119;   7'd90: m = 13'd108;
      7'd91: m = 13'd97;    7'd92: m = 13'd85;    7'd93: m = 13'd74;
      7'd94: m = 13'd63;    7'd95: m = 13'd53;    7'd96: m = 13'd42;
      7'd97: m = 13'd31;    7'd98: m = 13'd21;    7'd99: m = 13'd10;
      default: m = 13'd0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> src/mdp_front.sv
`default_nettype none

module mdp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire mdp_pkg::cmd_t cmd_i,
  input  wire mdp_pkg::cfg_t cfg_i,
  output logic               valid_o,
  output mdp_pkg::item_t     item_o
);
  import mdp_pkg::*;

  // stage 1: classify, clamp humidity, split percent
  logic               s1_v_q;
  status_e            s1_status_q, s1_status_d;
  logic signed [15:0] s1_temp_q;
  logic [15:0]        s1_den_q;
  logic [13:0]        s1_rh_q, s1_rh_d;
  logic [6:0]         s1_pct_q;

  logic signed [17:0] den_full;
  logic [13:0]        lim;
  logic [25:0]        pct_mul;

  assign den_full = 18'(cmd_i.temperature) + 18'sd23770;
  assign pct_mul  = 26'(s1_rh_d) * 26'd5243;

  always_comb begin
    if (cmd_i.temperature < cfg_i.temp_min || cmd_i.temperature > cfg_i.temp_max) begin
      s1_status_d = ST_RANGE;
    end else if (den_full <= 18'sd0) begin
      s1_status_d = ST_MATH;
    end else begin
      s1_status_d = ST_OK;
    end
    if (cfg_i.rh_max < RhFloor) begin
      lim = RhFloor;
    end else if (cfg_i.rh_max > RhTop) begin
      lim = RhTop;
    end else begin
      lim = cfg_i.rh_max;
    end
    if (cmd_i.humidity < 16'(RhFloor)) begin
      s1_rh_d = RhFloor;
    end else if (cmd_i.humidity > 16'(lim)) begin
      s1_rh_d = lim;
    end else begin
      s1_rh_d = cmd_i.humidity[13:0];
    end
  end

  // stage 2: table lookup and interpolation product
  logic               s2_v_q;
  status_e            s2_status_q;
  logic signed [15:0] s2_temp_q;
  logic [15:0]        s2_den_q;
  logic [12:0]        s2_mag_q, s2_mag_d;
  logic [16:0]        s2_prod_q, s2_prod_d;

  logic [13:0] frac_w;
  logic [12:0] mag_hi;
  logic [9:0]  step_span;

  always_comb begin
    frac_w   = s1_rh_q - 14'(s1_pct_q) * 14'(Cent);
    s2_mag_d = ln_mag(s1_pct_q);
    mag_hi   = (s1_pct_q < PctTop) ? ln_mag(7'(s1_pct_q + 7'd1)) : s2_mag_d;
    step_span = 10'(s2_mag_d - mag_hi);
    s2_prod_d = 17'(step_span) * 17'(frac_w[6:0]);
  end

  // stage 3: divide step by 100, truncating
  logic   s3_v_q;
  item_t  s3_item_q, s3_item_d;
  logic [33:0] step_mul;
  logic [12:0] ln_mag_w;

  always_comb begin
    step_mul = 34'(s2_prod_q) * 34'd167773;
    ln_mag_w = s2_mag_q - 13'(step_mul[33:24]);
    s3_item_d.status = s2_status_q;
    s3_item_d.temp   = s2_temp_q;
    s3_item_d.den    = s2_den_q;
    s3_item_d.ln_h   = -$signed({1'b0, ln_mag_w});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_status_q <= s1_status_d;
    s1_temp_q   <= cmd_i.temperature;
    s1_den_q    <= den_full[15:0];
    s1_rh_q     <= s1_rh_d;
    s1_pct_q    <= pct_mul[25:19];
    s2_status_q <= s1_status_q;
    s2_temp_q   <= s1_temp_q;
    s2_den_q    <= s1_den_q;
    s2_mag_q    <= s2_mag_d;
    s2_prod_q   <= s2_prod_d;
    s3_item_q   <= s3_item_d;
  end

  assign valid_o = s3_v_q;
  assign item_o  = s3_item_q;

endmodule

`default_nettype wire

>>> src/mdp_queue.sv
`default_nettype none

module mdp_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire mdp_pkg::item_t item_i,
  input  wire logic           pop_i,
  output logic                valid_o,
  output mdp_pkg::item_t      item_o,
  output logic                full_o
);
  import mdp_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  item_t             mem_q [QDepth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(QDepth));
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QDepth - 1)) ? '0 : PtrW'(wr_q + 1'b1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QDepth - 1)) ? '0 : PtrW'(rd_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

>>> src/mdp_div.sv
`default_nettype none

// pipelined restoring divider, one quotient bit per stage
module mdp_div #(
  parameter int unsigned N = 31,
  parameter int unsigned D = 16,
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  input  wire logic [N-1:0] num_i,
  input  wire logic [D-1:0] den_i,
  input  wire logic [W-1:0] tag_i,
  output logic              valid_o,
  output logic [N-1:0]      quo_o,
  output logic [W-1:0]      tag_o
);

  logic [N-1:0] nq_q  [N];
  logic [D-1:0] rem_q [N];
  logic [D-1:0] den_q [N];
  logic [W-1:0] tag_q [N];
  logic [N-1:0] vld_q;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [N-1:0] nq_in;
    logic [D-1:0] rem_in, den_in;
    logic [W-1:0] tag_in;
    logic         v_in;
    logic [D:0]   trial, diff;
    logic         take;
    logic [N-1:0] nq_d;
    logic [D-1:0] rem_d;

    if (k == 0) begin : g_first
      assign nq_in  = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
      assign tag_in = tag_i;
      assign v_in   = valid_i;
    end else begin : g_next
      assign nq_in  = nq_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign tag_in = tag_q[k-1];
      assign v_in   = vld_q[k-1];
    end

    assign trial = {rem_in, nq_in[N-1]};
    assign diff  = trial - {1'b0, den_in};
    assign take  = (trial >= {1'b0, den_in});
    assign nq_d  = {nq_in[N-2:0], take};
    assign rem_d = take ? diff[D-1:0] : trial[D-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      nq_q[k]  <= nq_d;
      rem_q[k] <= rem_d;
      den_q[k] <= den_in;
      tag_q[k] <= tag_in;
    end
  end

  assign valid_o = vld_q[N-1];
  assign quo_o   = nq_q[N-1];
  assign tag_o   = tag_q[N-1];

endmodule

`default_nettype wire

>>> src/mdp_back.sv
`default_nettype none

module mdp_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire mdp_pkg::item_t item_i,
  input  wire mdp_pkg::cfg_t  cfg_i,
  output logic                valid_o,
  output mdp_pkg::result_t    result_o
);
  import mdp_pkg::*;

  typedef struct packed {
    status_e            status;
    logic signed [15:0] temp;
    logic signed [13:0] ln_h;
    logic               neg;
  } tag1_t;

  typedef struct packed {
    status_e            status;
    logic signed [15:0] temp;
    logic               neg;
  } tag2_t;

  localparam int unsigned N1 = 31;
  localparam int unsigned D1 = 16;
  localparam int unsigned N2 = 45;
  localparam int unsigned D2 = 30;

  // a*T
  logic               s0_v_q;
  logic signed [30:0] s0_prod_q;
  logic [15:0]        s0_den_q;
  status_e            s0_status_q;
  logic signed [15:0] s0_temp_q;
  logic signed [13:0] s0_ln_q;

  // rounding bias, sign split
  logic           s1_v_q;
  logic [N1-1:0]  s1_num_q, s1_num_d;
  logic [D1-1:0]  s1_den_q;
  tag1_t          s1_tag_q, s1_tag_d;
  logic [29:0]    mag1;

  always_comb begin
    mag1 = s0_prod_q[30] ? 30'(-s0_prod_q) : s0_prod_q[29:0];
    s1_num_d = N1'(mag1) + N1'(s0_den_q >> 1);
    s1_tag_d.status = s0_status_q;
    s1_tag_d.temp   = s0_temp_q;
    s1_tag_d.ln_h   = s0_ln_q;
    s1_tag_d.neg    = s0_prod_q[30];
  end

  logic          d1_v;
  logic [N1-1:0] d1_q;
  logic [$bits(tag1_t)-1:0] d1_tag_raw;
  tag1_t         d1_tag;

  mdp_div #(.N(N1), .D(D1), .W($bits(tag1_t))) u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_v_q),
    .num_i   (s1_num_q),
    .den_i   (s1_den_q),
    .tag_i   (s1_tag_q),
    .valid_o (d1_v),
    .quo_o   (d1_q),
    .tag_o   (d1_tag_raw)
  );
  assign d1_tag = tag1_t'(d1_tag_raw);

  // alpha and second denominator
  logic               s2_v_q;
  logic signed [31:0] s2_alpha_q, s2_alpha_d;
  logic [D2-1:0]      s2_den_q;
  status_e            s2_status_q, s2_status_d;
  logic signed [15:0] s2_temp_q;
  logic signed [31:0] q1s, term1;
  logic signed [32:0] den_a;

  always_comb begin
    q1s        = $signed({1'b0, d1_q});
    term1      = d1_tag.neg ? -q1s : q1s;
    s2_alpha_d = term1 + 32'(d1_tag.ln_h);
    den_a      = 33'($signed({1'b0, MagA})) - 33'(s2_alpha_d);
    s2_status_d = d1_tag.status;
    if (d1_tag.status == ST_OK && den_a <= 33'sd0) begin
      s2_status_d = ST_MATH;
    end
  end

  // b*alpha
  logic               s3_v_q;
  logic signed [46:0] s3_prod_q;
  logic [D2-1:0]      s3_den_q;
  status_e            s3_status_q;
  logic signed [15:0] s3_temp_q;

  // rounding bias, sign split
  logic           s4_v_q;
  logic [N2-1:0]  s4_num_q, s4_num_d;
  logic [D2-1:0]  s4_den_q;
  tag2_t          s4_tag_q, s4_tag_d;
  logic [43:0]    mag2;

  always_comb begin
    mag2 = s3_prod_q[46] ? 44'(-s3_prod_q) : s3_prod_q[43:0];
    s4_num_d = N2'(mag2) + N2'(s3_den_q >> 1);
    s4_tag_d.status = s3_status_q;
    s4_tag_d.temp   = s3_temp_q;
    s4_tag_d.neg    = s3_prod_q[46];
  end

  logic          d2_v;
  logic [N2-1:0] d2_q;
  logic [$bits(tag2_t)-1:0] d2_tag_raw;
  tag2_t         d2_tag;

  mdp_div #(.N(N2), .D(D2), .W($bits(tag2_t))) u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s4_v_q),
    .num_i   (s4_num_q),
    .den_i   (s4_den_q),
    .tag_i   (s4_tag_q),
    .valid_o (d2_v),
    .quo_o   (d2_q),
    .tag_o   (d2_tag_raw)
  );
  assign d2_tag = tag2_t'(d2_tag_raw);

  // sign, clamps, output register
  logic               out_v_q;
  result_t            out_q, out_d;
  logic signed [46:0] q2s, dew;

  always_comb begin
    q2s = $signed({2'b0, d2_q});
    dew = d2_tag.neg ? -q2s : q2s;
    if (dew > 47'(d2_tag.temp)) begin
      dew = 47'(d2_tag.temp);
    end
    if (dew < 47'(cfg_i.temp_min)) begin
      dew = 47'(cfg_i.temp_min);
    end
    if (dew > 47'(cfg_i.temp_max)) begin
      dew = 47'(cfg_i.temp_max);
    end
    out_d.status    = d2_tag.status;
    out_d.dew_point = (d2_tag.status == ST_OK) ? dew[15:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s0_v_q  <= valid_i;
      s1_v_q  <= s0_v_q;
      s2_v_q  <= d1_v;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      out_v_q <= d2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_prod_q   <= 31'($signed({1'b0, MagA})) * 31'(item_i.temp);
    s0_den_q    <= item_i.den;
    s0_status_q <= item_i.status;
    s0_temp_q   <= item_i.temp;
    s0_ln_q     <= item_i.ln_h;
    s1_num_q    <= s1_num_d;
    s1_den_q    <= s0_den_q;
    s1_tag_q    <= s1_tag_d;
    s2_alpha_q  <= s2_alpha_d;
    s2_den_q    <= den_a[D2-1:0];
    s2_status_q <= s2_status_d;
    s2_temp_q   <= d1_tag.temp;
    s3_prod_q   <= 47'($signed({1'b0, MagB})) * 47'(s2_alpha_q);
    s3_den_q    <= s2_den_q;
    s3_status_q <= s2_status_q;
    s3_temp_q   <= s2_temp_q;
    s4_num_q    <= s4_num_d;
    s4_den_q    <= s3_den_q;
    s4_tag_q    <= s4_tag_d;
    out_q       <= out_d;
  end

  assign valid_o  = out_v_q;
  assign result_o = out_q;

endmodule

`default_nettype wire

>>> src/magnus_dew_point_fixed_core.sv
// Magnus dew point core, fixed point.
// Pipeline: the accepting edge loads the first of 86 register stages (3 front, 1 queue,
// 2 + 31 + 3 + 45 + 1 back), the last of which drives the result strobe; throughput one item
// per cycle, set by the two bit-per-stage pipelined dividers. The receiver cannot
// stall, so busy stays low.
// Reset: asynchronous active low; pipeline emptied, registers to -40.00/85.00/100.00.
`default_nettype none

`include "magnus_dew_point_fixed_core_defines.svh"

module magnus_dew_point_fixed_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire mdp_pkg::cmd_t    cmd_i,
  output logic                  result_valid_o,
  output mdp_pkg::result_t      result_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [15:0]      cfg_data_i
);
  import mdp_pkg::*;

  logic signed [15:0] temp_min_q, temp_min_d;
  logic signed [15:0] temp_max_q, temp_max_d;
  logic [13:0]        rh_max_q, rh_max_d;
  cfg_t               cfg;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    temp_min_d = temp_min_q;
    temp_max_d = temp_max_q;
    rh_max_d   = rh_max_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_TEMP_MIN: temp_min_d = cfg_data_i;
        CFG_TEMP_MAX: temp_max_d = cfg_data_i;
        CFG_RH_MAX:   rh_max_d   = cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_min_q <= -16'sd4000;
      temp_max_q <= 16'sd8500;
      rh_max_q   <= 14'd10000;
    end else begin
      temp_min_q <= temp_min_d;
      temp_max_q <= temp_max_d;
      rh_max_q   <= rh_max_d;
    end
  end

  assign cfg.temp_min = temp_min_q;
  assign cfg.temp_max = temp_max_q;
  assign cfg.rh_max   = rh_max_q;

  logic  accept;
  logic  q_push, q_valid, q_full;
  item_t f_item, q_item;

  assign accept = start && !busy;
  assign busy   = q_full;

  mdp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .cmd_i   (cmd_i),
    .cfg_i   (cfg),
    .valid_o (q_push),
    .item_o  (f_item)
  );

  mdp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (f_item),
    .pop_i   (q_valid),
    .valid_o (q_valid),
    .item_o  (q_item),
    .full_o  (q_full)
  );

  mdp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .item_i   (q_item),
    .cfg_i    (cfg),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

  logic res_ok, res_fault, dew_in_cfg;

  assign res_ok     = result_valid_o && result_o.status == ST_OK;
  assign res_fault  = result_valid_o && result_o.status != ST_OK;
  assign dew_in_cfg = result_o.dew_point >= temp_min_q && result_o.dew_point <= temp_max_q;

  `MDP_ASSERT_IMP(a_no_overflow, q_push, !q_full)
  `MDP_ASSERT_NXT(a_queue_drains, q_valid && !q_push, !q_valid)
  `MDP_ASSERT_IMP(a_dew_in_range, res_ok, dew_in_cfg)
  `MDP_ASSERT_IMP(a_fault_zero, res_fault, result_o.dew_point == 16'sd0)

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mdp_pkg::*;

  typedef struct {
    bit              is_cfg;
    cfg_idx_e        idx;
    logic [15:0]     data;
    cmd_t            cmd;
  } job_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        cmd_i = '0;
  logic        result_valid_o;
  result_t     result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  job_t    jobs[$];
  result_t dew_due[$];
  int      n_errors = 0;
  int      n_accepted = 0;
  int      quiet_cycles = 0;
  int      ln_tab[101];

  // shadow of the register bank
  logic signed [15:0] t_lo = -16'sd4000;
  logic signed [15:0] t_hi = 16'sd8500;
  logic [13:0]        rh_lim = 14'd10000;

  magnus_dew_point_fixed_core dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .result_valid_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint div_half_away(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic int ln_humid_pred(int unsigned rh);
    int unsigned lim, pct, frac;
    int y0, y1;
    lim = rh_lim;
    if (lim < 100) lim = 100;
    if (lim > 10000) lim = 10000;
    if (rh < 100) rh = 100;
    if (rh > lim) rh = lim;
    pct = rh / 100;
    frac = rh % 100;
    y0 = ln_tab[pct];
    y1 = (pct < 100) ? ln_tab[pct + 1] : y0;
    return y0 + ((y1 - y0) * int'(frac)) / 100;
  endfunction

  function automatic result_t dew_predict(cmd_t c);
    result_t r;
    longint t, den_t, alpha, den_a, dew;
    r.status = ST_OK;
    r.dew_point = '0;
    t = c.temperature;
    if (t < t_lo || t > t_hi) begin
      r.status = ST_RANGE;
      return r;
    end
    den_t = 23770 + t;
    if (den_t <= 0) begin
      r.status = ST_MATH;
      return r;
    end
    alpha = div_half_away(17684 * t, den_t) + ln_humid_pred(c.humidity);
    den_a = 17684 - alpha;
    if (den_a <= 0) begin
      r.status = ST_MATH;
      return r;
    end
    dew = div_half_away(23770 * alpha, den_a);
    if (dew > t) dew = t;
    if (dew < t_lo) dew = t_lo;
    if (dew > t_hi) dew = t_hi;
    r.dew_point = dew[15:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  task automatic add_cmd(logic [15:0] t, logic [15:0] h);
    job_t j;
    j.is_cfg = 1'b0;
    j.idx = CFG_TEMP_MIN;
    j.data = '0;
    j.cmd.temperature = t;
    j.cmd.humidity = h;
    jobs.push_back(j);
  endtask

  task automatic add_cfg(cfg_idx_e i, logic [15:0] d);
    job_t j;
    j.is_cfg = 1'b1;
    j.idx = i;
    j.data = d;
    j.cmd = '0;
    jobs.push_back(j);
  endtask

  // driver
  always @(posedge clk_i) begin
    logic nxt_start, nxt_cfg;
    int idle_pct;
    if (rst_ni) begin
      nxt_start = start;
      nxt_cfg = cfg_valid_i;
      if (start && !busy) begin
        dew_due.push_back(dew_predict(jobs[0].cmd));
        void'(jobs.pop_front());
        n_accepted++;
        nxt_start = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (jobs[0].idx)
          CFG_TEMP_MIN: t_lo = jobs[0].data;
          CFG_TEMP_MAX: t_hi = jobs[0].data;
          default: rh_lim = jobs[0].data[13:0];
        endcase
        void'(jobs.pop_front());
        nxt_cfg = 1'b0;
      end
      quiet_cycles = (dew_due.size() == 0 && !start) ? quiet_cycles + 1 : 0;
      idle_pct = (n_accepted < 420) ? 36 : (n_accepted < 840) ? 51 : 0;
      if (!nxt_start && !nxt_cfg && jobs.size() > 0) begin
        if (jobs[0].is_cfg) begin
          if (quiet_cycles > 90) begin
            nxt_cfg = 1'b1;
            cfg_index_i <= jobs[0].idx;
            cfg_data_i <= jobs[0].data;
          end
        end else if ($urandom_range(99) >= idle_pct) begin
          nxt_start = 1'b1;
          cmd_i <= jobs[0].cmd;
        end
      end
      start <= nxt_start;
      cfg_valid_i <= nxt_cfg;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (dew_due.size() == 0) begin
        report_mismatch("unexpected result", result_o.dew_point, 0);
      end else begin
        want = dew_due.pop_front();
        if (result_o.status !== want.status)
          report_mismatch("status", result_o.status, want.status);
        if (result_o.dew_point !== want.dew_point)
          report_mismatch("dew_point", result_o.dew_point, want.dew_point);
      end
    end
  end

  initial begin
    logic signed [15:0] lo, hi;
    int tries;
    for (int p = 1; p <= 100; p++)
      ln_tab[p] = -$rtoi(-$ln(p / 100.0) * 1024.0 + 0.5);
    ln_tab[0] = 0;

    // directed, reset configuration
    add_cmd(16'sd2500, 16'd5000);
    add_cmd(-16'sd4000, 16'd0);
    add_cmd(16'sd8500, 16'd10000);
    add_cmd(-16'sd4001, 16'd5000);
    add_cmd(16'sd8501, 16'd5000);
    add_cmd(16'sh7fff, 16'hffff);
    add_cmd(16'sh8000, 16'd0);
    add_cmd(16'sd2000, 16'd99);
    add_cmd(16'sd2000, 16'd100);
    add_cmd(16'sd2000, 16'd9999);
    add_cmd(16'sd2000, 16'hffff);
    add_cmd(16'sd0, 16'd4567);
    // wide range: b + T not positive
    add_cfg(CFG_TEMP_MIN, 16'h8000);
    add_cfg(CFG_TEMP_MAX, 16'h7fff);
    add_cfg(CFG_RH_MAX, 16'h3fff);
    add_cmd(-16'sd23770, 16'd5000);
    add_cmd(16'sh8000, 16'd5000);
    add_cmd(-16'sd23769, 16'd5000);
    add_cmd(16'sh7fff, 16'd10000);
    add_cmd(16'sd20000, 16'd10000);
    add_cmd(-16'sd20000, 16'd100);
    add_cfg(CFG_RH_MAX, 16'd0);
    add_cmd(16'sd2500, 16'd8000);
    add_cmd(16'sd2500, 16'd50);
    // empty range
    add_cfg(CFG_TEMP_MIN, 16'sd100);
    add_cfg(CFG_TEMP_MAX, -16'sd100);
    add_cmd(16'sd0, 16'd5000);

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin lo = -16'sd20000; hi = 16'sd20000; end
        1: begin lo = -16'sd4000; hi = 16'sd8500; end
        2: begin lo = 16'sh8000; hi = 16'sh7fff; end
        default: begin
          lo = $urandom_range(40000) - 20000;
          hi = $urandom_range(40000) - 20000;
          if ($urandom_range(9) != 0 && lo > hi) begin
            tries = lo; lo = hi; hi = tries;
          end
        end
      endcase
      add_cfg(CFG_TEMP_MIN, lo);
      add_cfg(CFG_TEMP_MAX, hi);
      case (ph)
        0: add_cfg(CFG_RH_MAX, 16'd100);
        1: add_cfg(CFG_RH_MAX, 16'd10000);
        2: add_cfg(CFG_RH_MAX, 16'd16383);
        default: add_cfg(CFG_RH_MAX, $urandom_range(16383));
      endcase
      for (int k = 0; k < 125; k++) begin
        logic [15:0] t, h;
        case ($urandom_range(3))
          0: t = $urandom_range(65535);
          1: t = (lo <= hi) ? lo + $urandom_range(hi - lo) : $urandom_range(65535);
          2: t = $urandom_range(12000) - 4000;
          default: t = (lo <= hi) ? (($urandom_range(1)) ? lo : hi) : 16'sd0;
        endcase
        case ($urandom_range(3))
          0: h = $urandom_range(65535);
          1: h = $urandom_range(300);
          default: h = $urandom_range(10100);
        endcase
        add_cmd(t, h);
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (jobs.size() != 0 || dew_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (n_errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #(20 * 400000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
